// File: rtl/core/b64sc_pkg.sv
`default_nettype none

package b64sc_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [7:0] ChPad   = 8'h3D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChDig0  = 8'h30;
  localparam logic [7:0] ChDig9  = 8'h39;

  localparam logic RegDecodeMode = 1'b0;
  localparam logic RegPadEnable  = 1'b1;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic            bad;
    logic [2:0]      count;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = ChUpA + {2'b00, v};
    end else if (v < 6'd52) begin
      c = ChLoA + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = ChDig0 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = ChPlus;
    end else begin
      c = ChSlash;
    end
    return c;
  endfunction

  // Bit 6 set marks a character outside the alphabet.
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h40;
    if (c >= ChUpA && c <= ChUpZ) begin
      d = c - ChUpA;
    end else if (c >= ChLoA && c <= ChLoZ) begin
      d = c - ChLoA + 8'd26;
    end else if (c >= ChDig0 && c <= ChDig9) begin
      d = c - ChDig0 + 8'd52;
    end else if (c == ChPlus) begin
      d = 8'd62;
    end else if (c == ChSlash) begin
      d = 8'd63;
    end
    return d[6:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/b64sc_front.sv
`default_nettype none

module b64sc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic          cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  input  wire logic          q_full,
  output logic               push,
  output b64sc_pkg::job_t    push_job
);
  import b64sc_pkg::*;

  logic        decode_mode;
  logic        pad_enable;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic [1:0]  pad_count;
  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic [1:0]  pad_count_next;

  logic        accept;
  logic [2:0]  enc_n;
  logic [23:0] enc_bits;
  logic [23:0] enc_v;
  logic        enc_flush;
  logic [2:0]  enc_nc;
  logic [6:0]  dec_s;
  logic        is_pad;
  logic        dec_bad;
  logic [5:0]  sext;
  logic [1:0]  pc_new;
  logic [23:0] dec_bits;
  logic [2:0]  dec_n;
  logic [23:0] fl_bits;
  logic [2:0]  fl_n;
  logic [1:0]  fl_pc;
  logic [23:0] fl_v;
  logic [1:0]  nb_raw;
  logic [1:0]  nb;
  logic        do_flush;
  logic [2:0]  flush_count;
  job_t        job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    enc_n     = {1'b0, group_count} + 3'd1;
    enc_bits  = {group_bits[15:0], in_byte};
    enc_flush = (enc_n >= 3'd3) || in_last;
    case (enc_n)
      3'd1:    enc_v = {enc_bits[7:0], 16'h0000};
      3'd2:    enc_v = {enc_bits[15:0], 8'h00};
      default: enc_v = enc_bits;
    endcase
    enc_nc = (enc_n >= 3'd3) ? 3'd4 : enc_n + 3'd1;

    dec_s    = char_sextet(in_byte);
    is_pad   = (in_byte == ChPad);
    dec_bad  = !is_pad && dec_s[6];
    sext     = is_pad ? 6'd0 : dec_s[5:0];
    pc_new   = (is_pad && pad_count != 2'd3) ? pad_count + 2'd1 : pad_count;
    dec_bits = {group_bits[17:0], sext};
    dec_n    = {1'b0, group_count} + 3'd1;

    if (dec_bad) begin
      fl_bits  = group_bits;
      fl_n     = {1'b0, group_count};
      fl_pc    = pad_count;
      do_flush = in_last && (group_count != 2'd0);
    end else begin
      fl_bits  = dec_bits;
      fl_n     = dec_n;
      fl_pc    = pc_new;
      do_flush = (dec_n == 3'd4) || in_last;
    end
    case (fl_n)
      3'd1:    fl_v = {fl_bits[5:0], 18'h00000};
      3'd2:    fl_v = {fl_bits[11:0], 12'h000};
      3'd3:    fl_v = {fl_bits[17:0], 6'h00};
      default: fl_v = fl_bits;
    endcase
    nb_raw      = (fl_n == 3'd4) ? 2'd3 : 2'(fl_n - 3'd1);
    nb          = (nb_raw > fl_pc) ? nb_raw - fl_pc : 2'd0;
    flush_count = do_flush ? {1'b0, nb} : 3'd0;

    job = '0;
    if (!decode_mode) begin
      for (int i = 0; i < 4; i++) begin
        job.bytes[i] = (3'(i) < enc_nc) ? sextet_char(enc_v[23 - 6 * i -: 6]) : ChPad;
      end
      job.count = enc_flush ? (pad_enable ? 3'd4 : enc_nc) : 3'd0;
      if (enc_flush) begin
        group_bits_next  = '0;
        group_count_next = '0;
      end else begin
        group_bits_next  = enc_bits;
        group_count_next = enc_n[1:0];
      end
      pad_count_next = '0;
    end else if (dec_bad) begin
      job.bytes = {fl_v[7:0], fl_v[15:8], fl_v[23:16], 8'h00};
      job.bad   = 1'b1;
      job.count = flush_count + 3'd1;
      if (in_last) begin
        group_bits_next  = '0;
        group_count_next = '0;
        pad_count_next   = '0;
      end else begin
        group_bits_next  = group_bits;
        group_count_next = group_count;
        pad_count_next   = pad_count;
      end
    end else begin
      job.bytes = {8'h00, fl_v[7:0], fl_v[15:8], fl_v[23:16]};
      job.count = flush_count;
      if (do_flush) begin
        group_bits_next  = '0;
        group_count_next = '0;
        pad_count_next   = '0;
      end else begin
        group_bits_next  = dec_bits;
        group_count_next = dec_n[1:0];
        pad_count_next   = pc_new;
      end
    end
  end

  assign push     = accept && (job.count != 3'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      pad_enable  <= 1'b1;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegDecodeMode) begin
        decode_mode <= cfg_data;
        group_bits  <= '0;
        group_count <= '0;
        pad_count   <= '0;
      end else if (cfg_index == RegPadEnable) begin
        pad_enable <= cfg_data;
      end
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_count   <= pad_count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/b64sc_queue.sv
`default_nettype none

module b64sc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire b64sc_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output b64sc_pkg::job_t    q_job
);
  import b64sc_pkg::*;

  job_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;

  assign full    = (count == (QPtrW + 1)'(QDepth));
  assign q_valid = (count != '0);
  assign q_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPtrW + 1)'(QDepth))
    else $error("queue holds more items than its depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: rtl/core/b64sc_back.sv
`default_nettype none

module b64sc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire b64sc_pkg::job_t q_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               bad_char
);
  import b64sc_pkg::*;

  job_t       cur;
  logic [2:0] rem;
  logic       take;
  logic       load;

  assign out_valid = (rem != 3'd0);
  assign out_byte  = cur.bytes[0];
  assign bad_char  = cur.bad;
  assign out_last  = (rem == 3'd1);
  assign take      = out_valid && out_ready;
  assign load      = q_valid && (!out_valid || (take && out_last));
  assign pop       = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= q_job.count;
    end else if (take) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_job;
    end else if (take) begin
      cur <= '{bytes: {8'h00, cur.bytes[3:1]}, bad: 1'b0, count: cur.count};
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_char) |-> (out_byte == 8'h00))
    else $error("error item carries a non-zero byte");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (take && out_last && !q_valid) |=> !out_valid)
    else $error("output still valid after the last item drained");

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    load |-> (q_job.count != 3'd0))
    else $error("empty job reached the output stage");

endmodule

`default_nettype wire

// File: rtl/core/base64_stream_codec_top.sv
`default_nettype none

// Streaming base64 codec. The input channel (in_valid/in_ready) carries one
// byte or character per item with in_last marking the end of a message; the
// output channel (out_valid/out_ready) carries one character or byte per item,
// with out_last on the final result caused by an input item and bad_char on
// the single error result for a character outside the alphabet.
// The user must write configuration through cfg_we, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this.
// Index 0 selects decoding, index 1 enables '=' padding, and writing the mode
// abandons any partial group. An input item is taken every cycle while the
// two-entry job queue has room; the output side issues one result per cycle
// while out_ready is high, so the rate is set by the output: a full encode
// group of three bytes yields four characters, a decode group of four
// characters yields at most three bytes. The first result of an item is
// registered in the job queue and then in the output stage before it shows.
// Reset clears the group state, selects encoding and enables padding.
// When the receiver stalls, the current result holds, the queue fills and
// in_ready falls once both entries are taken.

module base64_stream_codec_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            bad_char
);
  import b64sc_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic q_valid;
  job_t q_job;

  b64sc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  b64sc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  b64sc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .bad_char  (bad_char)
  );

endmodule

`default_nettype wire
